// ===== rtl/wtms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtms_pkg
// Shared types and constants for the Welch t max statistic block.
// ----------------------------------------------------------------------------
package wtms_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int T_BITS           = 32;
    localparam int MAX_SUBJECTS_DEF = 256;
    localparam int T_FRAC_BITS_DEF  = 16;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          in_group_one;
        logic                          last_of_voxel;
        logic                          last_of_permutation;
    } t_in_item;

    typedef struct packed {
        logic signed [T_BITS-1:0] t_value;
        logic                     degenerate;
        logic signed [T_BITS-1:0] max_t_value;
        logic                     permutation_done;
    } t_out_item;

    typedef enum logic [4:0] {
        S_ACC, S_CHECK, S_NQ, S_SS, S_NN, S_NNN, S_TDIV_GO, S_TDIV_WAIT,
        S_SQRT_GO, S_SQRT_WAIT, S_M12, S_M21, S_NUM, S_DDIV_GO, S_DDIV_WAIT,
        S_TTDIV_GO, S_TTDIV_WAIT, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE, OP_ACCUM, OP_CHECK, OP_NQ, OP_SS, OP_NN, OP_NNN,
        OP_TDIV_GO, OP_TDIV_WAIT, OP_SQRT_GO, OP_SQRT_WAIT, OP_M12, OP_M21,
        OP_NUM, OP_DDIV_GO, OP_DDIV_WAIT, OP_TTDIV_GO, OP_TTDIV_WAIT, OP_FINAL
    } t_op;

    typedef struct packed {
        t_op  op;
        logic grp;
    } t_cmd;

    typedef struct packed {
        logic counts_ok;
        logic root_zero;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/welch_t_max_statistic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// welch_t_max_statistic
// Streaming Welch two-sample t statistic per voxel with a per-permutation max.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready, payload i_in_item): one subject
// sample per transaction, tagged with its group and with end-of-voxel and
// end-of-permutation marks. Samples are taken one per cycle while a voxel
// is accumulating.
// Output channel (o_out_valid / i_out_ready, payload o_out_item): one
// transaction per voxel, carrying t, the degenerate flag, the running max
// and the permutation-done mark.
// After the last sample of a voxel, two variance divides, one root and two
// more divides run in turn; the divider is 82 bits wide at the defaults (one
// quotient bit per cycle) and the root 42 bits (one root bit per cycle);
// all voxel-end divides and the root share one divider and one root unit.
// A degenerate voxel with too few samples skips straight to the result.
// No input is accepted during that computation.
// Reset clears all sums, counts and the running max. If the receiver stalls,
// the block keeps accumulating the next voxel and waits at its end until the
// output register is free.
// ----------------------------------------------------------------------------
module welch_t_max_statistic import wtms_pkg::*; #(
    parameter int MAX_SUBJECTS = MAX_SUBJECTS_DEF,
    parameter int T_FRAC_BITS  = T_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd    cmd;
    t_status status;

    wtms_controller u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_last_of_voxel (i_in_item.last_of_voxel),
        .i_status        (status),
        .o_in_ready      (o_in_ready),
        .o_cmd           (cmd)
    );

    wtms_datapath #(
        .MAX_SUBJECTS (MAX_SUBJECTS),
        .T_FRAC_BITS  (T_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_item),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/wtms_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtms_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtms_divider #(
    parameter int N = 8,
    parameter int M = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [M-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quotient
);

    localparam int CNTW = $clog2(N + 1);

    logic [N-1:0]    r_q;
    logic [M-1:0]    r_rem;
    logic [M-1:0]    r_dsr;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [M:0]      rem_sh;
    logic            ge;

    assign rem_sh = {r_rem, r_q[N-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[N-2:0], ge};
            r_rem <= ge ? M'(rem_sh - {1'b0, r_dsr}) : M'(rem_sh);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== rtl/wtms_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtms_sqrt
// Integer floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module wtms_sqrt #(
    parameter int RW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2*RW-1:0] i_value,
    output logic          o_done,
    output logic [RW-1:0] o_root
);

    localparam int CNTW = $clog2(RW + 1);

    logic [2*RW-1:0] r_x;
    logic [RW:0]     r_rem;
    logic [RW-1:0]   r_root;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic            ge;

    assign rem_sh = {r_rem, r_x[2*RW-1 -: 2]};
    assign trial  = (RW+3)'({r_root, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[2*RW-3:0], 2'b00};
            r_rem  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
            r_root <= {r_root[RW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/wtms_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtms_datapath
// Group accumulators, shared multiplier, divider and root unit, max tracking.
// ----------------------------------------------------------------------------
module wtms_datapath import wtms_pkg::*; #(
    parameter int MAX_SUBJECTS = MAX_SUBJECTS_DEF,
    parameter int T_FRAC_BITS  = T_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  logic      i_out_ready,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int CW   = $clog2(MAX_SUBJECTS + 1);
    localparam int SB   = SAMPLE_BITS;
    localparam int F    = T_FRAC_BITS;
    localparam int F2   = 2 * T_FRAC_BITS;
    localparam int SUMW = SB + CW;
    localparam int SQW  = 2 * SB + CW;
    localparam int AW   = SQW + CW;
    localparam int NW   = SUMW + CW + 1;
    localparam int WW   = AW + F2 + 1;
    localparam int RW   = (WW + 1) / 2;
    localparam int DVW  = ((AW > NW) ? AW : NW) + F2;
    localparam int DSW  = (3 * CW > RW) ? 3 * CW : RW;
    localparam int DMW  = NW + T_FRAC_BITS;
    localparam int MA   = SQW + 1;
    localparam int MB   = SUMW + 1;
    localparam int PW   = MA + MB;

    logic [CW-1:0]          r_n [2];
    logic signed [SUMW-1:0] r_s [2];
    logic [SQW-1:0]         r_q [2];
    logic signed [PW-1:0]   r_prod;
    logic [AW-1:0]          r_a;
    logic [WW-1:0]          r_w;
    logic [RW-1:0]          r_root;
    logic signed [NW-1:0]   r_num;
    logic [DMW-1:0]         r_dm;
    logic [DVW-1:0]         r_tm;
    logic                   r_degen;
    logic                   r_perm;
    logic signed [T_BITS-1:0] r_max;
    logic                   r_seen;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   g;
    logic                   ig;
    logic [CW-1:0]          n_g;
    logic signed [SUMW-1:0] s_g;
    logic [SQW-1:0]         q_g;
    logic signed [MA-1:0]   ma;
    logic signed [MB-1:0]   mb;
    logic                   mul_en;
    logic signed [2*SB-1:0] sq2;
    logic                   div_start;
    logic [DVW-1:0]         dvd;
    logic [DSW-1:0]         dsr;
    logic                   div_done;
    logic [DVW-1:0]         quo;
    logic                   sqrt_start;
    logic                   sqrt_done;
    logic [RW-1:0]          root;
    logic [NW-1:0]          num_mag;
    logic signed [T_BITS-1:0] t_sat;
    logic signed [T_BITS-1:0] t_fin;
    logic signed [T_BITS-1:0] max_new;
    logic                   upd;
    logic                   out_free;

    assign g   = i_cmd.grp;
    assign ig  = !i_item.in_group_one;
    assign n_g = r_n[g];
    assign s_g = r_s[g];
    assign q_g = r_q[g];
    assign sq2 = i_item.sample * i_item.sample;
    assign num_mag = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
    assign out_free = !r_out_valid || i_out_ready;

    // shared multiplier operand select
    always_comb begin
        ma     = '0;
        mb     = '0;
        mul_en = 1'b1;
        unique case (i_cmd.op)
            OP_NQ: begin
                ma = MA'({1'b0, q_g});
                mb = MB'(n_g);
            end
            OP_SS: begin
                ma = MA'(s_g);
                mb = MB'(s_g);
            end
            OP_NN: begin
                ma = MA'(n_g);
                mb = MB'(n_g);
            end
            OP_NNN: begin
                ma = MA'(r_prod[2*CW-1:0]);
                mb = MB'(n_g - 1'b1);
            end
            OP_M12: begin
                ma = MA'(r_s[0]);
                mb = MB'(r_n[1]);
            end
            OP_M21: begin
                ma = MA'(r_s[1]);
                mb = MB'(r_n[0]);
            end
            OP_NUM: begin
                ma = MA'(r_n[0]);
                mb = MB'(r_n[1]);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        dvd       = '0;
        dsr       = '0;
        unique case (i_cmd.op)
            OP_TDIV_GO: begin
                div_start = 1'b1;
                dvd       = DVW'({r_a, {F2{1'b0}}});
                dsr       = DSW'(r_prod[3*CW-1:0]);
            end
            OP_DDIV_GO: begin
                div_start = 1'b1;
                dvd       = DVW'({num_mag, {F{1'b0}}});
                dsr       = DSW'(r_prod[2*CW-1:0]);
            end
            OP_TTDIV_GO: begin
                div_start = 1'b1;
                dvd       = DVW'({r_dm, {F{1'b0}}});
                dsr       = DSW'(r_root);
            end
            default: div_start = 1'b0;
        endcase
    end

    assign sqrt_start = i_cmd.op == OP_SQRT_GO;

    wtms_divider #(.N(DVW), .M(DSW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dsr),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    wtms_sqrt #(.RW(RW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value ((2*RW)'(r_w)),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    // sign and saturation of the final quotient
    always_comb begin
        if (r_num[NW-1]) begin
            t_sat = (r_tm > DVW'(33'h080000000)) ? T_BITS'(33'h080000000)
                                                 : T_BITS'(-r_tm);
        end else begin
            t_sat = (r_tm > DVW'(32'h7FFFFFFF)) ? T_BITS'(32'h7FFFFFFF)
                                                : T_BITS'(r_tm);
        end
        t_fin   = r_degen ? '0 : t_sat;
        upd     = !r_degen && (!r_seen || (t_fin > r_max));
        max_new = upd ? t_fin : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n[0]      <= '0;
            r_n[1]      <= '0;
            r_s[0]      <= '0;
            r_s[1]      <= '0;
            r_q[0]      <= '0;
            r_q[1]      <= '0;
            r_max       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_ACCUM) begin
                // a full group ignores further samples
                if (r_n[ig] < CW'(MAX_SUBJECTS)) begin
                    r_n[ig] <= r_n[ig] + 1'b1;
                    r_s[ig] <= r_s[ig] + SUMW'(i_item.sample);
                    r_q[ig] <= r_q[ig] + SQW'($unsigned(sq2));
                end
            end
            if (i_cmd.op == OP_FINAL) begin
                r_n[0]      <= '0;
                r_n[1]      <= '0;
                r_s[0]      <= '0;
                r_s[1]      <= '0;
                r_q[0]      <= '0;
                r_q[1]      <= '0;
                r_out_valid <= 1'b1;
                if (r_perm) begin
                    r_max  <= '0;
                    r_seen <= 1'b0;
                end else begin
                    r_max  <= max_new;
                    r_seen <= r_seen || upd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= ma * mb;
        end
        case (i_cmd.op)
            OP_ACCUM: r_perm <= i_item.last_of_voxel && i_item.last_of_permutation;
            OP_CHECK: begin
                r_w     <= '0;
                r_degen <= !o_status.counts_ok;
            end
            OP_SS:  r_a <= AW'(r_prod);
            OP_NN:  r_a <= r_a - AW'(r_prod);
            OP_TDIV_WAIT: begin
                if (div_done) begin
                    r_w <= r_w + WW'(quo);
                end
            end
            OP_SQRT_WAIT: begin
                if (sqrt_done) begin
                    r_root  <= root;
                    r_degen <= root == '0;
                end
            end
            OP_M21: r_num <= NW'(r_prod);
            OP_NUM: r_num <= r_num - NW'(r_prod);
            OP_DDIV_WAIT: begin
                if (div_done) begin
                    r_dm <= DMW'(quo);
                end
            end
            OP_TTDIV_WAIT: begin
                if (div_done) begin
                    r_tm <= quo;
                end
            end
            OP_FINAL: begin
                r_out.t_value          <= t_fin;
                r_out.degenerate       <= r_degen;
                r_out.max_t_value      <= max_new;
                r_out.permutation_done <= r_perm;
            end
            default: ;
        endcase
    end

    assign o_status.counts_ok = (r_n[0] >= CW'(2)) && (r_n[1] >= CW'(2));
    assign o_status.root_zero = root == '0;
    assign o_status.div_done  = div_done;
    assign o_status.sqrt_done = sqrt_done;
    assign o_status.out_free  = out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/wtms_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtms_controller
// Sequencer for accumulation and the voxel-end statistic computation.
// ----------------------------------------------------------------------------
module wtms_controller import wtms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_of_voxel,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_grp, n_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_grp   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_grp   <= n_grp;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_grp      = r_grp;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_IDLE;
        o_cmd.grp  = r_grp;
        unique case (r_state)
            S_ACC: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCUM;
                    if (i_last_of_voxel) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_grp    = 1'b0;
                n_state  = i_status.counts_ok ? S_NQ : S_FIN;
            end
            S_NQ: begin
                o_cmd.op = OP_NQ;
                n_state  = S_SS;
            end
            S_SS: begin
                o_cmd.op = OP_SS;
                n_state  = S_NN;
            end
            S_NN: begin
                o_cmd.op = OP_NN;
                n_state  = S_NNN;
            end
            S_NNN: begin
                o_cmd.op = OP_NNN;
                n_state  = S_TDIV_GO;
            end
            S_TDIV_GO: begin
                o_cmd.op = OP_TDIV_GO;
                n_state  = S_TDIV_WAIT;
            end
            S_TDIV_WAIT: begin
                o_cmd.op = OP_TDIV_WAIT;
                if (i_status.div_done) begin
                    if (!r_grp) begin
                        n_grp   = 1'b1;
                        n_state = S_NQ;
                    end else begin
                        n_state = S_SQRT_GO;
                    end
                end
            end
            S_SQRT_GO: begin
                o_cmd.op = OP_SQRT_GO;
                n_state  = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                o_cmd.op = OP_SQRT_WAIT;
                if (i_status.sqrt_done) begin
                    n_state = i_status.root_zero ? S_FIN : S_M12;
                end
            end
            S_M12: begin
                o_cmd.op = OP_M12;
                n_state  = S_M21;
            end
            S_M21: begin
                o_cmd.op = OP_M21;
                n_state  = S_NUM;
            end
            S_NUM: begin
                o_cmd.op = OP_NUM;
                n_state  = S_DDIV_GO;
            end
            S_DDIV_GO: begin
                o_cmd.op = OP_DDIV_GO;
                n_state  = S_DDIV_WAIT;
            end
            S_DDIV_WAIT: begin
                o_cmd.op = OP_DDIV_WAIT;
                if (i_status.div_done) begin
                    n_state = S_TTDIV_GO;
                end
            end
            S_TTDIV_GO: begin
                o_cmd.op = OP_TTDIV_GO;
                n_state  = S_TTDIV_WAIT;
            end
            S_TTDIV_WAIT: begin
                o_cmd.op = OP_TTDIV_WAIT;
                if (i_status.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // wait for the output register to free up
                if (i_status.out_free) begin
                    o_cmd.op = OP_FINAL;
                    n_state  = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

endmodule

// ===== test/welch_t_max_statistic_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// welch_t_max_statistic_checker
// Watches both channels, predicts each voxel result from the accepted samples
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module welch_t_max_statistic_checker import wtms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int N_MAX = MAX_SUBJECTS_DEF;
    localparam int FRAC  = T_FRAC_BITS_DEF;

    int unsigned     n_one, n_two;
    longint          acc_one, acc_two;
    longint unsigned sq_one, sq_two;
    longint          peak_t;
    bit              peak_valid;
    t_out_item       voxel_results[$];

    assign o_pending = voxel_results.size();

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // var/n in Q.2F, floored in two steps
    function automatic longint unsigned var_over_n(int unsigned n, longint s,
                                                   longint unsigned q);
        longint unsigned sm, a, d;
        sm = abs64(s);
        a = longint'(n) * q - sm * sm;
        d = longint'(n) * longint'(n) * longint'(n - 1);
        return ((a / d) << (2 * FRAC)) + (((a % d) << (2 * FRAC)) / d);
    endfunction

    function automatic void clear_voxel();
        n_one = 0; n_two = 0; acc_one = 0; acc_two = 0; sq_one = 0; sq_two = 0;
    endfunction

    function automatic void predict_voxel(t_in_item it);
        longint          x, t, num;
        longint unsigned w, s, dm, tm;
        bit              degen;
        t_out_item       r;
        x = longint'(it.sample);
        t = 0;
        degen = 1;
        if (it.in_group_one) begin
            if (n_one < N_MAX) begin
                n_one++; acc_one += x; sq_one += abs64(x) * abs64(x);
            end
        end else if (n_two < N_MAX) begin
            n_two++; acc_two += x; sq_two += abs64(x) * abs64(x);
        end
        if (!it.last_of_voxel) return;
        if (n_one >= 2 && n_two >= 2) begin
            w = var_over_n(n_one, acc_one, sq_one) + var_over_n(n_two, acc_two, sq_two);
            s = isqrt64(w);
            if (s != 0) begin
                num = acc_one * longint'(n_two) - acc_two * longint'(n_one);
                dm = (abs64(num) << FRAC) / (longint'(n_one) * longint'(n_two));
                tm = (dm << FRAC) / s;
                if (num < 0) t = tm > (64'd1 << 31) ? -(64'sd1 <<< 31) : -longint'(tm);
                else t = tm > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(tm);
                degen = 0;
            end
        end
        if (!degen && (!peak_valid || t > peak_t)) begin
            peak_t = t;
            peak_valid = 1;
        end
        r.t_value = t[31:0];
        r.degenerate = degen;
        r.max_t_value = peak_t[31:0];
        r.permutation_done = it.last_of_permutation;
        voxel_results.push_back(r);
        clear_voxel();
        if (it.last_of_permutation) begin
            peak_t = 0;
            peak_valid = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            clear_voxel();
            peak_t = 0;
            peak_valid = 0;
            voxel_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (voxel_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result transaction: %p", i_out_item);
                end else begin
                    exp_r = voxel_results.pop_front();
                    if (exp_r !== i_out_item) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10) begin
                            $write("mismatch: t exp %0d act %0d, degen exp %0b act %0b, ",
                                   exp_r.t_value, i_out_item.t_value,
                                   exp_r.degenerate, i_out_item.degenerate);
                            $display("max exp %0d act %0d, done exp %0b act %0b",
                                     exp_r.max_t_value, i_out_item.max_t_value,
                                     exp_r.permutation_done,
                                     i_out_item.permutation_done);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_voxel(i_in_item);
        end
    end

endmodule

// ===== test/welch_t_max_statistic_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// welch_t_max_statistic_tb
// Streams voxels of grouped samples with random gaps and output stalls;
// the checker predicts every voxel's t, flag and running max.
// ----------------------------------------------------------------------------
module welch_t_max_statistic_tb;
    import wtms_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    bit        no_idle;

    welch_t_max_statistic dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    welch_t_max_statistic_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ready <= 0;
        else out_ready <= no_idle || ($urandom_range(99) >= 25);
    end

    task automatic send_sample(logic signed [15:0] s, bit g, bit lv, bit lp);
        while (!no_idle && $urandom_range(99) < 25) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        in_item <= '{sample: s, in_group_one: g, last_of_voxel: lv,
                     last_of_permutation: lp};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample(int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'sh7FFF - 16'($urandom_range(3));
            2: return 16'sh8000 + 16'($urandom_range(3));
            default: return 16'($urandom_range(200)) - 16'sd100;
        endcase
    endfunction

    // one voxel of n samples; groups mixed at random
    task automatic send_voxel(int n, bit lp, int style);
        for (int k = 0; k < n; k++)
            send_sample(pick_sample(style), 1'($urandom_range(1)), k == n - 1,
                        k == n - 1 ? lp : 1'($urandom_range(1)));
    endtask

    int sent;

    initial begin
        i_rst_n = 0;
        in_valid = 0;
        in_item = '0;
        no_idle = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // lone sample, zero spread, extremes
        send_sample(16'sh7FFF, 1'b1, 1'b1, 1'b1);
        send_sample(16'sd5, 1'b1, 1'b0, 1'b1); send_sample(16'sd5, 1'b1, 1'b0, 1'b0);
        send_sample(16'sd5, 1'b0, 1'b0, 1'b0); send_sample(16'sd5, 1'b0, 1'b1, 1'b0);
        send_sample(16'sh7FFF, 1'b1, 1'b0, 1'b0); send_sample(16'sh7FFF, 1'b1, 1'b0, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0, 1'b0); send_sample(16'sh8001, 1'b0, 1'b1, 1'b0);
        send_sample(16'sh8000, 1'b1, 1'b0, 1'b0); send_sample(16'sh8001, 1'b1, 1'b0, 1'b0);
        send_sample(16'sh7FFF, 1'b0, 1'b0, 1'b0); send_sample(16'sh7FFE, 1'b0, 1'b1, 1'b1);
        send_sample(-16'sd3, 1'b1, 1'b0, 1'b0); send_sample(16'sd2, 1'b1, 1'b0, 1'b0);
        send_sample(16'sd0, 1'b0, 1'b0, 1'b0); send_sample(16'sd1, 1'b0, 1'b1, 1'b1);
        // group one overflows the subject limit
        for (int k = 0; k < 262; k++)
            send_sample(k[0] ? 16'sd100 : -16'sd7, 1'b1, 1'b0, 1'b0);
        send_sample(16'sd1, 1'b0, 1'b0, 1'b0); send_sample(16'sd3, 1'b0, 1'b1, 1'b1);
        in_valid <= 0;
        wait (pending == 0);
        repeat (300) @(posedge i_clk);
        sent = 0;
        while (sent < 1300) begin
            int n;
            no_idle = (sent > 600 && sent < 800);
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 3) : $urandom_range(8, 1);
            send_voxel(n, $urandom_range(3) == 0, $urandom_range(4));
            sent += n;
        end
        send_voxel(4, 1'b1, 3);
        in_valid <= 0;
        wait (pending == 0);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
